/* design/capnp_dfr_pkg.sv */
// Shared types and constants for the Cap'n Proto stream message deframer.
// Holds field widths, reset values, register indexes and the state and error codes.
// No dependencies.
package capnp_dfr_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 27;
  localparam int SEG_W   = 10;
  localparam int SUM_W   = 24;
  localparam int MAXB_W  = 27;
  localparam int WORD_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;
  localparam int TOT_W   = LEN_W + 1;
  localparam int PAY_W   = SUM_W + 3;

  localparam logic [SEG_W-1:0]  SEG_CAP        = SEG_W'(512);
  localparam logic [SEG_W-1:0]  SEG_SAT        = '1;
  localparam logic [SEG_W-1:0]  MAX_SEG_RST    = SEG_W'(512);
  localparam logic [MAXB_W-1:0] MAX_BYTES_RST  = MAXB_W'(64 * 1024 * 1024);
  localparam logic [LEN_W-1:0]  LEN_MASK       = '1;
  localparam logic [SUM_W-1:0]  SUM_SAT        = '1;
  localparam logic [LEN_W-1:0]  FIRST_SIZE_END = LEN_W'(8);

  typedef enum logic [0:0] {
    REG_MAX_SEG   = 1'b0,
    REG_MAX_BYTES = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_COUNT   = 2'd0,
    PH_SIZES   = 2'd1,
    PH_PAD     = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_SEG_COUNT = 2'd1,
    ERR_SIZE      = 2'd2,
    ERR_TRUNC     = 2'd3
  } err_t;

  typedef struct packed {
    logic [SEG_W-1:0]  max_segments;
    logic [MAXB_W-1:0] max_message_bytes;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              message_start;
    logic              message_end;
    logic [LEN_W-1:0]  message_length;
    err_t              error_code;
  } res_t;

endpackage

/* design/capnp_dfr_cfg.sv */
// Configuration register file with an APB-style slave port.
// Holds the segment count limit and the message size limit; uses capnp_dfr_pkg.
module capnp_dfr_cfg
  import capnp_dfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [SEG_W-1:0]  max_seg_r;
  logic [MAXB_W-1:0] max_bytes_r;
  reg_idx_t          reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_seg_r   <= MAX_SEG_RST;
      max_bytes_r <= MAX_BYTES_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_SEG:   max_seg_r   <= pwdata[SEG_W-1:0];
        REG_MAX_BYTES: max_bytes_r <= pwdata[MAXB_W-1:0];
        default:       max_seg_r   <= max_seg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_SEG:   prdata = DATA_W'(max_seg_r);
      REG_MAX_BYTES: prdata = DATA_W'(max_bytes_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg.max_segments      = max_seg_r;
  assign cfg.max_message_bytes = max_bytes_r;

endmodule

/* design/capnp_dfr_framer.sv */
// Framing state machine: tracks the count word, size table, padding and payload
// of each message and forms the result for one byte per step. Uses capnp_dfr_pkg.
module capnp_dfr_framer
  import capnp_dfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              end_of_stream,
  input  cfg_t              cfg,
  output res_t              res
);

  // Frame state.
  phase_t            phase_r, phase_nxt;
  logic [1:0]        bow_r, bow_nxt;
  logic [BYTE_W-1:0] asm_r [3];
  logic [SEG_W-1:0]  seg_total_r, seg_total_nxt;
  logic [SEG_W-1:0]  segs_left_r, segs_left_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              exc_r, exc_nxt;
  logic [LEN_W-1:0]  bytes_r, bytes_nxt;
  logic [LEN_W-1:0]  pl_r, pl_nxt;
  err_t              err_r, err_nxt;

  // Decode of the current byte.
  logic              active;
  logic [LEN_W-1:0]  bytes_inc;
  logic [LEN_W-1:0]  pl_dec;
  logic              word_done;
  logic [WORD_W-1:0] word;
  logic [SEG_W-1:0]  seg_cnt;
  logic [SEG_W-1:0]  seg_lim;
  logic              seg_bad;
  logic [SUM_W:0]    sum_add;
  logic              sum_sat;
  logic [SUM_W-1:0]  sum_upd;
  logic              size_word;
  logic [SEG_W-1:0]  segs_dec;
  logic              table_done;
  logic [SUM_W-1:0]  sum_cur;
  logic              exc_cur;
  logic [PAY_W-1:0]  payload;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  limit;
  logic              size_bad;
  logic              start_c;
  logic              end_c;
  err_t              err_out;

  always_comb begin
    active    = (err_r == ERR_NONE);
    bytes_inc = bytes_r + LEN_W'(1);
    pl_dec    = pl_r - LEN_W'(1);
    word_done = (phase_r != PH_PAYLOAD) && (bow_r == 2'd3);
    word      = {data_byte, asm_r[2], asm_r[1], asm_r[0]};

    // The count word holds segments minus one; huge values pin at the all-ones count.
    if ((|word[WORD_W-1:SEG_W]) || (word[SEG_W-1:0] == SEG_SAT)) begin
      seg_cnt = SEG_SAT;
    end else begin
      seg_cnt = word[SEG_W-1:0] + SEG_W'(1);
    end

    seg_lim = (cfg.max_segments < SEG_CAP) ? cfg.max_segments : SEG_CAP;
    seg_bad = (phase_r == PH_SIZES) && word_done && (bytes_inc == FIRST_SIZE_END) &&
              (seg_total_r > seg_lim);

    sum_add   = {1'b0, sum_r} + {1'b0, word[SUM_W-1:0]};
    sum_sat   = (|word[WORD_W-1:SUM_W]) || sum_add[SUM_W];
    sum_upd   = sum_sat ? SUM_SAT : sum_add[SUM_W-1:0];
    size_word = (phase_r == PH_SIZES) && word_done && !seg_bad;
    segs_dec  = segs_left_r - SEG_W'(1);

    table_done = (size_word && (segs_dec == '0) && seg_total_r[0]) ||
                 ((phase_r == PH_PAD) && word_done);

    sum_cur = size_word ? sum_upd : sum_r;
    exc_cur = exc_r || (size_word && sum_sat);
    payload = {sum_cur, 3'b000};
    total   = TOT_W'(bytes_inc) + TOT_W'(payload);
    limit   = (TOT_W'(cfg.max_message_bytes) > TOT_W'(LEN_MASK)) ? TOT_W'(LEN_MASK)
                                                                : TOT_W'(cfg.max_message_bytes);
    size_bad = table_done && (exc_cur || (total > limit));

    start_c = (phase_r == PH_COUNT) && (bytes_r == '0);
    end_c   = ((phase_r == PH_PAYLOAD) && (pl_dec == '0)) ||
              (table_done && !size_bad && (sum_cur == '0));

    priority if (!active) begin
      err_out = err_r;
    end else if (seg_bad) begin
      err_out = ERR_SEG_COUNT;
    end else if (size_bad) begin
      err_out = ERR_SIZE;
    end else if (end_of_stream && !end_c) begin
      err_out = ERR_TRUNC;
    end else begin
      err_out = ERR_NONE;
    end
  end

  // Next state.
  always_comb begin
    phase_nxt     = phase_r;
    bow_nxt       = bow_r;
    seg_total_nxt = seg_total_r;
    segs_left_nxt = segs_left_r;
    sum_nxt       = sum_r;
    exc_nxt       = exc_r;
    bytes_nxt     = bytes_r;
    pl_nxt        = pl_r;
    err_nxt       = err_out;

    if (active) begin
      bytes_nxt = bytes_inc;
      if (phase_r == PH_PAYLOAD) begin
        pl_nxt = pl_dec;
      end else begin
        bow_nxt = bow_r + 2'd1;
        if (word_done) begin
          unique case (phase_r)
            PH_COUNT: begin
              seg_total_nxt = seg_cnt;
              segs_left_nxt = seg_cnt;
              phase_nxt     = PH_SIZES;
            end
            PH_SIZES: begin
              if (size_word) begin
                sum_nxt       = sum_upd;
                exc_nxt       = exc_cur;
                segs_left_nxt = segs_dec;
                if ((segs_dec == '0) && !seg_total_r[0]) begin
                  phase_nxt = PH_PAD;
                end
              end
            end
            default: phase_nxt = phase_r;
          endcase
        end
      end
      if (table_done && !size_bad && (sum_cur != '0)) begin
        pl_nxt    = LEN_W'(payload);
        phase_nxt = PH_PAYLOAD;
      end
    end

    // A finished message or the end of the stream restarts framing.
    if ((active && end_c) || end_of_stream) begin
      phase_nxt = PH_COUNT;
      bow_nxt   = 2'd0;
      sum_nxt   = '0;
      exc_nxt   = 1'b0;
      bytes_nxt = '0;
    end
  end

  // Result for this byte.
  always_comb begin
    res.byte_out       = data_byte;
    res.error_code     = err_out;
    res.message_start  = active && start_c && (err_out == ERR_NONE);
    res.message_end    = active && end_c && (err_out == ERR_NONE);
    res.message_length = res.message_end ? bytes_inc : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      bow_r   <= 2'd0;
      sum_r   <= '0;
      exc_r   <= 1'b0;
      bytes_r <= '0;
      err_r   <= ERR_NONE;
    end else if (step) begin
      phase_r <= phase_nxt;
      bow_r   <= bow_nxt;
      sum_r   <= sum_nxt;
      exc_r   <= exc_nxt;
      bytes_r <= bytes_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      seg_total_r <= seg_total_nxt;
      segs_left_r <= segs_left_nxt;
      pl_r        <= pl_nxt;
      if (active && (phase_r != PH_PAYLOAD) && (bow_r != 2'd3)) begin
        asm_r[bow_r] <= data_byte;
      end
    end
  end

  // An error, once taken, never changes until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ERR_NONE) |=> (err_r == $past(err_r)))
    else $error("sticky error changed");

  // The payload phase always has bytes left to count.
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (pl_r != '0))
    else $error("payload phase with zero bytes left");

  // Word assembly is only partway through in the header phases.
  a_bow_header: assert property (@(posedge clk) disable iff (!rst_n)
    (bow_r != 2'd0) |-> (phase_r != PH_PAYLOAD))
    else $error("partial header word during payload");

  // A completed message leaves the framer ready for the next count word.
  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.message_end) |=> ((phase_r == PH_COUNT) && (bytes_r == '0)))
    else $error("framer did not restart after message end");

endmodule

/* design/capnp_message_deframer_core.sv */
// An accepted byte is registered in the input stage, then in the result stage when the framer steps.
// Throughput: one byte per cycle while out_ready holds; the framing step is a single pass through the framer.
// The input register and the result register let a new transfer in while a result waits.
// Reset (rst_n, synchronous, active low) clears both stages, the framing state and
// the sticky error, and loads the limits with 512 segments and 64 MiB.
module capnp_message_deframer_core
  import capnp_dfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  // Byte stream in.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_end_of_stream,

  // Passed-through bytes with framing marks.
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte_out,
  output logic              out_message_start,
  output logic              out_message_end,
  output logic [LEN_W-1:0]  out_message_length,
  output logic [1:0]        out_error_code,

  // Configuration.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // Input stage holds one accepted byte until the framer consumes it.
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_eos_r;

  // Result stage.
  logic              out_vld_r;
  res_t              out_r;

  cfg_t              cfg;
  res_t              res;
  logic              adv;

  // The framer steps whenever the input stage holds a byte and the result stage
  // is empty or being drained in the same cycle.
  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
      in_eos_r  <= in_end_of_stream;
    end
  end

  capnp_dfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  capnp_dfr_framer u_framer (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (adv),
    .data_byte     (in_byte_r),
    .end_of_stream (in_eos_r),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_byte_out       = out_r.byte_out;
  assign out_message_start  = out_r.message_start;
  assign out_message_end    = out_r.message_end;
  assign out_message_length = out_r.message_length;
  assign out_error_code     = out_r.error_code;

  // A byte is never dropped: a full input stage that cannot advance stays full.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r)
    else $error("input stage lost a byte");

  // A framer step always lands a valid result.
  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("framer step produced no result");

  // A result that is not taken is not overwritten.
  a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |-> !adv)
    else $error("result overwritten before transfer");

endmodule
